[hw/rtl/epoch_to_date_time_assert.svh]
// Assertion macros for the checker file of this block.
`ifndef EPOCH_TO_DATE_TIME_ASSERT_SVH
`define EPOCH_TO_DATE_TIME_ASSERT_SVH

// Condition in a cycle implies a consequence in the same cycle.
`define ETD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Condition in a cycle implies a consequence in the following cycle.
`define ETD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/etd_pkg.sv]
package etd_pkg;

  // Input and working widths.
  localparam int EPOCH_W = 32;
  localparam int PROD_W  = 2 * EPOCH_W;
  localparam int DAYS_W  = 16;
  localparam int REM_W   = 6;
  localparam int ALU_W   = DAYS_W + 1;

  // Output field widths.
  localparam int YEAR_W  = 12;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int SEC_W   = 6;
  localparam int WDAY_W  = 3;

  // Divisors for the time-of-day split and the weekday.
  localparam logic [REM_W-1:0] SEC_PER_MIN  = REM_W'(60);
  localparam logic [REM_W-1:0] MIN_PER_HOUR = REM_W'(60);
  localparam logic [REM_W-1:0] HOUR_PER_DAY = REM_W'(24);
  localparam logic [REM_W-1:0] DAY_PER_WEEK = REM_W'(7);

  // Reciprocals: the quotient is (x * m) >> s for every operand the sequencer feeds in.
  localparam logic [EPOCH_W-1:0] RECIP_60    = 32'h8888_8889;
  localparam int                 RECIP_60_SH = 37;
  localparam logic [EPOCH_W-1:0] RECIP_24    = 32'hAAAA_AAAB;
  localparam int                 RECIP_24_SH = 36;
  localparam logic [EPOCH_W-1:0] RECIP_7     = 32'h2492_4925;
  localparam int                 RECIP_7_SH  = 32;

  // 1970-01-01 was a Thursday: offset so that Monday maps to zero.
  localparam logic [DAYS_W-1:0] WDAY_OFFSET = DAYS_W'(3);

  // Calendar constants.
  localparam logic [YEAR_W-1:0] EPOCH_YEAR     = YEAR_W'(1970);
  localparam int                CENT_W         = 7;
  localparam int                QUAD_W         = 9;
  localparam logic [CENT_W-1:0] CENT_LEN       = CENT_W'(100);
  localparam logic [QUAD_W-1:0] QUAD_LEN       = QUAD_W'(400);
  localparam logic [CENT_W-1:0] EPOCH_MOD_CENT = CENT_W'(1970 % 100);
  localparam logic [QUAD_W-1:0] EPOCH_MOD_QUAD = QUAD_W'(1970 % 400);
  localparam logic [DAYS_W-1:0] YEAR_DAYS      = DAYS_W'(365);
  localparam logic [DAYS_W-1:0] LEAP_YEAR_DAYS = DAYS_W'(366);

  // Month numbers used by the length table and the month walk.
  localparam logic [MONTH_W-1:0] MON_JAN = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] MON_FEB = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] MON_APR = MONTH_W'(4);
  localparam logic [MONTH_W-1:0] MON_JUN = MONTH_W'(6);
  localparam logic [MONTH_W-1:0] MON_SEP = MONTH_W'(9);
  localparam logic [MONTH_W-1:0] MON_NOV = MONTH_W'(11);
  localparam logic [MONTH_W-1:0] MON_DEC = MONTH_W'(12);

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_SEC,
    ST_DIV_MIN,
    ST_DIV_HOUR,
    ST_DIV_WDAY,
    ST_YEAR,
    ST_MONTH
  } state_t;

  // Control bundle from the sequencer to the datapath.
  typedef struct packed {
    logic               div_mode;
    logic [REM_W-1:0]   divisor;
    logic [EPOCH_W-1:0] recip;
    logic               div_last;
  } ctrl_t;

  // Days in a month, with February following the leap flag.
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] mon,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    case (mon) inside
      MON_FEB: len = leap ? DAY_W'(29) : DAY_W'(28);
      MON_APR, MON_JUN, MON_SEP, MON_NOV: len = DAY_W'(30);
      default: len = DAY_W'(31);
    endcase
    return len;
  endfunction

endpackage

[hw/rtl/epoch_to_date_time.sv]
// Channel    Ports                                          Direction  Handshake
// request    start, epoch_seconds                           in         start & !busy
// result     done, year, month, day, hour, minute,          out        done pulse
//            second, weekday
//
// Four divisions by 60, 60, 24 and 7 each run as a 32 by 32 multiply by a reciprocal
// constant, then a shift and a small remainder subtract. The year walk then takes off
// whole years and the month walk whole months, on one shared 17-bit subtractor.
// done pulses in the cycle after the last step; busy is high from the accepted request
// until then. Reset is synchronous and idles the sequencer. The receiver cannot stall.
module epoch_to_date_time (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [etd_pkg::EPOCH_W-1:0] epoch_seconds,
  output logic                        busy,
  output logic                        done,
  output logic [etd_pkg::YEAR_W-1:0]  year,
  output logic [etd_pkg::MONTH_W-1:0] month,
  output logic [etd_pkg::DAY_W-1:0]   day,
  output logic [etd_pkg::HOUR_W-1:0]  hour,
  output logic [etd_pkg::MIN_W-1:0]   minute,
  output logic [etd_pkg::SEC_W-1:0]   second,
  output logic [etd_pkg::WDAY_W-1:0]  weekday
);
  import etd_pkg::*;

  state_t state, state_next;
  ctrl_t  ctrl;

  logic [EPOCH_W-1:0] num;
  logic [PROD_W-1:0]  prod;
  logic               phase;
  logic [DAYS_W-1:0]  days;
  logic [YEAR_W-1:0]  yr;
  logic [CENT_W-1:0]  mod_cent;
  logic [QUAD_W-1:0]  mod_quad;
  logic [MONTH_W-1:0] mon;
  logic [SEC_W-1:0]   sec_q;
  logic [MIN_W-1:0]   min_q;
  logic [HOUR_W-1:0]  hour_q;
  logic [WDAY_W-1:0]  wday_q;

  logic               accept;
  logic               leap;
  logic [DAYS_W-1:0]  alu_a, alu_b;
  logic [ALU_W-1:0]   diff;
  logic               ge;
  logic [EPOCH_W-1:0] quot;
  logic [REM_W-1:0]   rem;
  logic               year_found;
  logic               month_found;

  assign accept = start && !busy;

  // Gregorian leap rule from the running year residues.
  assign leap = ((yr[1:0] == 2'b00) && (mod_cent != '0)) || (mod_quad == '0);

  // Shared subtract/compare unit: remaining days against a year or a month length.
  always_comb begin
    alu_a = days;
    if (state == ST_YEAR) begin
      alu_b = leap ? LEAP_YEAR_DAYS : YEAR_DAYS;
    end else begin
      alu_b = DAYS_W'(month_len(mon, leap));
    end
  end

  assign diff        = {1'b0, alu_a} - {1'b0, alu_b};
  assign ge          = !diff[ALU_W-1];
  assign year_found  = !ge;
  assign month_found = !ge || (mon == MON_DEC);

  // Quotient by reciprocal multiplication; the shift follows the divisor.
  always_comb begin
    unique case (state)
      ST_DIV_HOUR: quot = EPOCH_W'(prod >> RECIP_24_SH);
      ST_DIV_WDAY: quot = EPOCH_W'(prod >> RECIP_7_SH);
      default:     quot = EPOCH_W'(prod >> RECIP_60_SH);
    endcase
  end

  // The remainder is below 64, so the six low bits of the difference carry it.
  assign rem = num[REM_W-1:0] - REM_W'(quot[REM_W-1:0] * ctrl.divisor);

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (start) state_next = ST_DIV_SEC;
      ST_DIV_SEC:  if (ctrl.div_last) state_next = ST_DIV_MIN;
      ST_DIV_MIN:  if (ctrl.div_last) state_next = ST_DIV_HOUR;
      ST_DIV_HOUR: if (ctrl.div_last) state_next = ST_DIV_WDAY;
      ST_DIV_WDAY: if (ctrl.div_last) state_next = ST_YEAR;
      ST_YEAR:     if (year_found) state_next = ST_MONTH;
      ST_MONTH:    if (month_found) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    busy          = 1'b1;
    ctrl.div_mode = 1'b0;
    ctrl.divisor  = SEC_PER_MIN;
    ctrl.recip    = RECIP_60;
    ctrl.div_last = phase;
    unique case (state)
      ST_IDLE: begin
        busy = 1'b0;
      end
      ST_DIV_SEC: begin
        ctrl.div_mode = 1'b1;
        ctrl.divisor  = SEC_PER_MIN;
        ctrl.recip    = RECIP_60;
      end
      ST_DIV_MIN: begin
        ctrl.div_mode = 1'b1;
        ctrl.divisor  = MIN_PER_HOUR;
        ctrl.recip    = RECIP_60;
      end
      ST_DIV_HOUR: begin
        ctrl.div_mode = 1'b1;
        ctrl.divisor  = HOUR_PER_DAY;
        ctrl.recip    = RECIP_24;
      end
      ST_DIV_WDAY: begin
        ctrl.div_mode = 1'b1;
        ctrl.divisor  = DAY_PER_WEEK;
        ctrl.recip    = RECIP_7;
      end
      ST_YEAR, ST_MONTH: begin
        ctrl.div_mode = 1'b0;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  // Result strobe, raised in the cycle after the month walk ends.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == ST_MONTH) && month_found;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      num      <= epoch_seconds;
      phase    <= 1'b0;
      yr       <= EPOCH_YEAR;
      mod_cent <= EPOCH_MOD_CENT;
      mod_quad <= EPOCH_MOD_QUAD;
      mon      <= MON_JAN;
    end else if (ctrl.div_mode) begin
      phase <= !phase;
      if (!ctrl.div_last) begin
        // First phase: 32 by 32 product of the operand and the reciprocal.
        prod <= PROD_W'(num) * PROD_W'(ctrl.recip);
      end else begin
        // Second phase: keep the remainder and pass the quotient on.
        unique case (state)
          ST_DIV_SEC: begin
            sec_q <= SEC_W'(rem);
            num   <= quot;
          end
          ST_DIV_MIN: begin
            min_q <= MIN_W'(rem);
            num   <= quot;
          end
          ST_DIV_HOUR: begin
            hour_q <= HOUR_W'(rem);
            days   <= quot[DAYS_W-1:0];
            num    <= quot + EPOCH_W'(WDAY_OFFSET);
          end
          ST_DIV_WDAY: wday_q <= WDAY_W'(rem) + WDAY_W'(1);
          default: ;
        endcase
      end
    end else if (state == ST_YEAR) begin
      // Take off one whole year while the remaining days cover it.
      if (ge) begin
        days     <= diff[DAYS_W-1:0];
        yr       <= yr + YEAR_W'(1);
        mod_cent <= (mod_cent == CENT_LEN - CENT_W'(1)) ? '0 : mod_cent + CENT_W'(1);
        mod_quad <= (mod_quad == QUAD_LEN - QUAD_W'(1)) ? '0 : mod_quad + QUAD_W'(1);
      end
    end else if (state == ST_MONTH) begin
      // Take off one whole month while the remaining days cover it.
      if (!month_found) begin
        days <= diff[DAYS_W-1:0];
        mon  <= mon + MONTH_W'(1);
      end
    end
  end

  // Result fields hold steady from the end of a conversion to the next start.
  assign year    = yr;
  assign month   = mon;
  assign day     = days[DAY_W-1:0] + DAY_W'(1);
  assign hour    = hour_q;
  assign minute  = min_q;
  assign second  = sec_q;
  assign weekday = wday_q;

endmodule

[hw/rtl/etd_checker.sv]
`include "epoch_to_date_time_assert.svh"

module etd_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        start,
  input logic [etd_pkg::EPOCH_W-1:0] epoch_seconds,
  input logic                        busy,
  input logic                        done,
  input logic [etd_pkg::YEAR_W-1:0]  year,
  input logic [etd_pkg::MONTH_W-1:0] month,
  input logic [etd_pkg::DAY_W-1:0]   day,
  input logic [etd_pkg::HOUR_W-1:0]  hour,
  input logic [etd_pkg::MIN_W-1:0]   minute,
  input logic [etd_pkg::SEC_W-1:0]   second,
  input logic [etd_pkg::WDAY_W-1:0]  weekday
);

  // A result arrives only once the block has finished its work.
  `ETD_ASSERT_SAME(a_done_idle, clk, rst, done, !busy, "done while busy")

  // An accepted transaction always makes the block busy.
  `ETD_ASSERT_NEXT(a_start_busy, clk, rst, start && !busy, busy, "start not taken")

  // The block never turns busy on its own.
  `ETD_ASSERT_SAME(a_busy_cause, clk, rst, $rose(busy), $past(start), "busy without start")

  // Every delivered result is a legal date and time.
  `ETD_ASSERT_SAME(a_result_range, clk, rst, done,
                   (month >= 4'd1) && (month <= 4'd12) && (day >= 5'd1) &&
                   (hour <= 5'd23) && (minute <= 6'd59) && (second <= 6'd59) &&
                   (weekday >= 3'd1) && (year >= 12'd1970) && (year <= 12'd2106),
                   "result out of range")

endmodule

bind epoch_to_date_time etd_checker u_etd_checker (.*);

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import etd_pkg::*;

  // Cycles without any transaction before the run is declared hung.
  localparam int HANG_LIMIT   = 2000;
  // Quiet cycles after the last result.
  localparam int DRAIN_CYCLES = 300;
  localparam int SEC_PER_DAY  = 86400;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [2:0]  weekday;
  } civil_time_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [31:0] epoch_seconds = '0;
  logic        busy;
  logic        done;
  logic [11:0] year;
  logic [3:0]  month;
  logic [4:0]  day;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;
  logic [2:0]  weekday;

  civil_time_t pending_dates[$];
  civil_time_t oldest_date;
  int          error_count = 0;
  int          conversions_sent = 0;
  int          results_seen = 0;
  int          leap_days_sent = 0;
  int          late_years_sent = 0;
  int          hang_cycles = 0;
  bit          idling_on = 1'b1;

  epoch_to_date_time u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .epoch_seconds(epoch_seconds),
    .busy         (busy),
    .done         (done),
    .year         (year),
    .month        (month),
    .day          (day),
    .hour         (hour),
    .minute       (minute),
    .second       (second),
    .weekday      (weekday)
  );

  // Free-running 50 MHz clock.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Gregorian leap rule.
  function automatic bit is_leap(input int unsigned yr);
    return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
  endfunction

  function automatic int unsigned days_in_month(input int unsigned yr, input int unsigned mon);
    int unsigned len;
    case (mon)
      MON_FEB: len = is_leap(yr) ? 29 : 28;
      MON_APR, MON_JUN, MON_SEP, MON_NOV: len = 30;
      default: len = 31;
    endcase
    return len;
  endfunction

  // Expected calendar fields for a count of seconds since the epoch.
  function automatic civil_time_t to_civil(input logic [31:0] secs);
    civil_time_t ct;
    int unsigned rest, days, yr, mon, len;
    ct.second  = 6'(secs % 60);
    rest       = secs / 60;
    ct.minute  = 6'(rest % 60);
    rest       = rest / 60;
    ct.hour    = 5'(rest % 24);
    days       = rest / 24;
    // Day zero was a Thursday; Monday is one.
    ct.weekday = 3'((days + 3) % 7 + 1);
    yr = 1970;
    len = is_leap(yr) ? 366 : 365;
    while (days >= len) begin
      days -= len;
      yr++;
      len = is_leap(yr) ? 366 : 365;
    end
    mon = 1;
    while (mon < 12 && days >= days_in_month(yr, mon)) begin
      days -= days_in_month(yr, mon);
      mon++;
    end
    ct.year  = 12'(yr);
    ct.month = 4'(mon);
    ct.day   = 5'(days + 1);
    return ct;
  endfunction

  // Seconds since the epoch for a calendar date and time, years 1970 to 2105.
  function automatic logic [31:0] epoch_of(input int unsigned yr, input int unsigned mon,
                                           input int unsigned dd, input int unsigned hh,
                                           input int unsigned mm, input int unsigned ss);
    longint unsigned days;
    days = dd - 1;
    for (int unsigned y = 1970; y < yr; y++) days += is_leap(y) ? 366 : 365;
    for (int unsigned m = 1; m < mon; m++) days += days_in_month(yr, m);
    return 32'(days * SEC_PER_DAY + hh * 3600 + mm * 60 + ss);
  endfunction

  // Offers one conversion and waits until the block takes it.
  task automatic send_epoch(input logic [31:0] secs);
    civil_time_t want;
    start         <= 1'b1;
    epoch_seconds <= secs;
    do @(posedge clk); while (busy);
    want = to_civil(secs);
    pending_dates.push_back(want);
    conversions_sent++;
    if (want.month == MON_FEB && want.day == 29) leap_days_sent++;
    if (want.year >= 2100) late_years_sent++;
  endtask

  // Random idle burst on the request side, sometimes after the block has gone idle.
  task automatic pause_input();
    int n;
    if (!idling_on || $urandom_range(2) == 0) return;
    n = $urandom_range(14, 1);
    start <= 1'b0;
    if ($urandom_range(1) == 1) begin
      while (pending_dates.size() != 0) @(posedge clk);
    end
    // Noise on the data lines while no transaction is offered.
    repeat (n) begin
      epoch_seconds <= $urandom();
      @(posedge clk);
    end
  endtask

  // Compares one result field and counts a mismatch.
  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", field, want, got);
      error_count++;
    end
  endtask

  // Each done strobe is one result transaction, matched against the oldest request.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_dates.size() == 0) begin
        $error("result transaction with no conversion pending");
        error_count++;
      end else begin
        oldest_date = pending_dates.pop_front();
        check_field("year", oldest_date.year, year);
        check_field("month", oldest_date.month, month);
        check_field("day", oldest_date.day, day);
        check_field("hour", oldest_date.hour, hour);
        check_field("minute", oldest_date.minute, minute);
        check_field("second", oldest_date.second, second);
        check_field("weekday", oldest_date.weekday, weekday);
        results_seen++;
      end
    end
  end

  // Hang detection: any accepted transaction restarts the count.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      hang_cycles <= 0;
    end else if (hang_cycles >= HANG_LIMIT) begin
      $display("no transaction for %0d cycles", HANG_LIMIT);
      $display("testbench: errors");
      $finish;
    end else begin
      hang_cycles <= hang_cycles + 1;
    end
  end

  // Field extremes around the epoch and the top of the 32-bit range.
  task automatic test_extremes();
    logic [31:0] corner_values[7];
    corner_values = '{32'd0, 32'd59, 32'd60, 32'd3599, 32'd86399, 32'd86400,
                      32'hFFFF_FFFF};
    foreach (corner_values[i]) begin
      send_epoch(corner_values[i]);
      pause_input();
    end
  endtask

  // Leap years: every fourth year, the century exception and the 400-year rule.
  task automatic test_leap_rules();
    send_epoch(epoch_of(1972, 2, 29, 0, 0, 0));
    send_epoch(epoch_of(2000, 2, 29, 12, 0, 0));
    pause_input();
    send_epoch(epoch_of(2000, 3, 1, 0, 0, 0));
    send_epoch(epoch_of(2100, 2, 28, 23, 59, 59));
    pause_input();
    send_epoch(epoch_of(2100, 3, 1, 0, 0, 0));
    send_epoch(epoch_of(2104, 12, 31, 23, 59, 59));
  endtask

  // Last second of every month: odd months in a common year, even months in a leap year.
  task automatic test_month_ends();
    int unsigned yr;
    for (int unsigned mon = 1; mon <= 12; mon++) begin
      yr = (mon % 2 == 1) ? 2023 : 2024;
      send_epoch(epoch_of(yr, mon, days_in_month(yr, mon), 23, 59, 59));
      pause_input();
    end
  endtask

  // Random mix: raw 32-bit values, day and month boundaries, both ends of the range.
  task automatic random_epochs(input int count);
    logic [31:0] secs;
    int unsigned yr, mon, dd;
    repeat (count) begin
      case ($urandom_range(9))
        0, 1, 2, 3: secs = $urandom();
        4, 5, 6, 7: begin
          yr  = $urandom_range(2105, 1970);
          mon = $urandom_range(12, 1);
          dd  = ($urandom_range(1) == 1) ? 1 : days_in_month(yr, mon);
          case ($urandom_range(2))
            0: secs = epoch_of(yr, mon, dd, 0, 0, 0);
            1: secs = epoch_of(yr, mon, dd, 23, 59, 59);
            default: secs = epoch_of(yr, mon, dd, $urandom_range(23), $urandom_range(59),
                                     $urandom_range(59));
          endcase
        end
        8: secs = $urandom_range(200000);
        default: secs = 32'hFFFF_FFFF - $urandom_range(200000);
      endcase
      send_epoch(secs);
      pause_input();
    end
  endtask

  task automatic test_random_epochs();
    idling_on = 1'b1;
    random_epochs(750);
  endtask

  // Requests held high continuously so each one follows the previous done at once.
  task automatic test_back_to_back();
    idling_on = 1'b0;
    random_epochs(100);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_leap_rules();
    test_month_ends();
    test_random_epochs();
    test_back_to_back();
    start <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("converted %0d epoch values, %0d results checked", conversions_sent,
             results_seen);
    $display("covered %0d leap days and %0d dates in 2100 or later", leap_days_sent,
             late_years_sent);
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
